### hw/rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and helpers of the code table converter.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int CODE_W        = 16;
	localparam int INDEX_W       = 15;
	localparam int CFG_INDEX_W   = 3;
	localparam int DEFAULT_DEPTH = 32768;
	localparam int SEARCH_STEPS  = 16;
	localparam int STEP_W        = $clog2(SEARCH_STEPS);
	localparam int BYTE_W        = 8;

	localparam logic [CODE_W-1:0] ASCII_LIMIT = 16'h0080;
	localparam logic [CODE_W-1:0] LIMIT_RESET = 16'hFFFF;

	localparam logic [CFG_INDEX_W-1:0] REG_TO_UNICODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LITTLE_ENDIAN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT  = 3'd4;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic init;
		logic issue;
		logic advance;
	} probe_ctrl_t;

	typedef struct packed {
		logic match;
		logic final_step;
		logic in_range;
	} probe_stat_t;

	function automatic code_t swap16(input code_t x);
		return {x[BYTE_W-1:0], x[CODE_W-1:BYTE_W]};
	endfunction

endpackage

### hw/rtl/ccc_ram.sv
// ----------------------------------------------------------------------------
// ccc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ccc_probe.sv
// ----------------------------------------------------------------------------
// ccc_probe
// Binary search unit: bounds, midpoint, probe count and key compare.
// ----------------------------------------------------------------------------
module ccc_probe #(
	parameter int TABLE_DEPTH = ccc_pkg::DEFAULT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ccc_pkg::probe_ctrl_t           ctrl,
	input  ccc_pkg::code_t                 entry_count,
	input  ccc_pkg::code_t                 search_code,
	input  ccc_pkg::code_t                 rd_key,
	output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output ccc_pkg::probe_stat_t           stat
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [ccc_pkg::CODE_W:0] DEPTH_LIM = (ccc_pkg::CODE_W+1)'(TABLE_DEPTH);

	ccc_pkg::code_t                    lo_q;
	ccc_pkg::code_t                    hi_q;
	ccc_pkg::code_t                    p_q;
	logic                              inr_q;
	logic [ccc_pkg::STEP_W-1:0]        step_q;
	ccc_pkg::code_t                    mid;
	ccc_pkg::code_t                    key_eff;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_addr = AW'(mid);
	assign key_eff = inr_q ? rd_key : '0;

	assign stat.match      = (search_code == key_eff);
	assign stat.final_step = (step_q == ccc_pkg::STEP_W'(ccc_pkg::SEARCH_STEPS - 1));
	assign stat.in_range   = inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctrl.init) begin
			step_q <= '0;
		end else if (ctrl.advance) begin
			step_q <= step_q + ccc_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			lo_q <= '0;
			hi_q <= entry_count;
		end else if (ctrl.advance) begin
			if (search_code > key_eff) begin
				lo_q <= p_q;
			end else begin
				hi_q <= p_q;
			end
		end
		if (ctrl.issue) begin
			p_q   <= mid;
			inr_q <= ({1'b0, mid} < DEPTH_LIM);
		end
	end

endmodule

### hw/rtl/charset_code_table_converter.sv
// ----------------------------------------------------------------------------
// charset_code_table_converter
// Converts 16-bit character codes through a loaded, sorted key/value table.
// ----------------------------------------------------------------------------
// A load request writes one table entry and leaves busy low. A convert request
// for a terminator or a code below 0x80 gives its result strobe in the cycle
// after acceptance; one after the string has ended or reached the output limit
// gives none. A code needing a table search takes, for each of up to sixteen
// probes, an address state and a registered table read and compare state; busy
// is high until its result appears. All probes share one compare unit.
// Results are presented for exactly one cycle on done and cannot be stalled.
// The table is not cleared: every entry must be loaded before it is searched.
// ----------------------------------------------------------------------------
module charset_code_table_converter #(
	parameter int TABLE_DEPTH = ccc_pkg::DEFAULT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ccc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ccc_pkg::CODE_W-1:0]        cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [ccc_pkg::INDEX_W-1:0]       entry_index,
	input  logic [ccc_pkg::CODE_W-1:0]        entry_key,
	input  logic [ccc_pkg::CODE_W-1:0]        entry_value,
	input  logic [ccc_pkg::CODE_W-1:0]        char_code,
	input  logic                              string_start,
	output logic                              done,
	output logic [ccc_pkg::CODE_W-1:0]        code,
	output logic                              found,
	output logic                              last
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [ccc_pkg::CODE_W:0] DEPTH_LIM = (ccc_pkg::CODE_W+1)'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;

	logic [1:0]            state_q;
	logic                  to_unicode_q;
	logic                  little_endian_q;
	ccc_pkg::code_t        entry_count_q;
	ccc_pkg::code_t        replacement_q;
	ccc_pkg::code_t        limit_q;
	ccc_pkg::code_t        pos_q;
	logic                  ended_q;
	ccc_pkg::code_t        chr_q;

	logic                  accept;
	logic                  load_req;
	logic                  conv_req;
	ccc_pkg::code_t        pos_eff;
	logic                  end_eff;
	ccc_pkg::code_t        chr_sw;
	logic                  run;
	logic                  lim_stop;
	logic                  imm_term;
	logic                  imm_pass;
	logic                  go_search;
	logic                  in_cmp;
	logic                  fin;
	logic                  fin_ok;
	logic                  fin_term;
	ccc_pkg::code_t        fin_val;
	ccc_pkg::code_t        val_eff;
	ccc_pkg::code_t        pos_next;
	ccc_pkg::code_t        res_code;
	logic                  res_last;

	logic                  ram_we;
	logic [AW-1:0]         ram_raddr;
	logic [2*ccc_pkg::CODE_W-1:0] ram_rdata;

	ccc_pkg::probe_ctrl_t  pctrl;
	ccc_pkg::probe_stat_t  pstat;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_req = accept && (kind == ccc_pkg::KIND_LOAD);
	assign conv_req = accept && (kind == ccc_pkg::KIND_CONVERT);
	assign ram_we   = load_req && ({2'b00, entry_index} < DEPTH_LIM);

	ccc_ram #(
		.WIDTH (2 * ccc_pkg::CODE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(entry_index)),
		.wdata ({entry_key, entry_value}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_cmp        = (state_q == ST_CMP);
	assign pctrl.init    = go_search;
	assign pctrl.issue   = (state_q == ST_READ);
	assign pctrl.advance = in_cmp && !pstat.match && !pstat.final_step;

	ccc_probe #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_probe (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (pctrl),
		.entry_count (entry_count_q),
		.search_code (chr_q),
		.rd_key      (ram_rdata[2*ccc_pkg::CODE_W-1:ccc_pkg::CODE_W]),
		.rd_addr     (ram_raddr),
		.stat        (pstat)
	);

	always_comb begin
		pos_eff   = string_start ? '0 : pos_q;
		end_eff   = string_start ? 1'b0 : ended_q;
		chr_sw    = (to_unicode_q && little_endian_q) ? ccc_pkg::swap16(char_code) : char_code;
		run       = conv_req && !end_eff && (pos_eff < limit_q);
		lim_stop  = conv_req && !end_eff && !(pos_eff < limit_q);
		imm_term  = run && (char_code == '0);
		imm_pass  = run && (char_code != '0) && (chr_sw < ccc_pkg::ASCII_LIMIT);
		go_search = run && (char_code != '0) && !(chr_sw < ccc_pkg::ASCII_LIMIT);

		val_eff   = pstat.in_range ? ram_rdata[ccc_pkg::CODE_W-1:0] : '0;
		fin       = imm_term || imm_pass || (in_cmp && (pstat.match || pstat.final_step));
		fin_ok    = imm_pass || (in_cmp && pstat.match);
		fin_val   = imm_pass ? chr_sw : val_eff;
		fin_term  = imm_term || (!fin_ok && (replacement_q == '0));
		pos_next  = (busy ? pos_q : pos_eff) + ccc_pkg::code_t'(1);

		if (fin_ok) begin
			res_code = (!to_unicode_q && little_endian_q) ? ccc_pkg::swap16(fin_val) : fin_val;
		end else if (fin_term) begin
			res_code = '0;
		end else begin
			res_code = replacement_q;
		end
		res_last = (!fin_ok && fin_term) || (pos_next >= limit_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_unicode_q    <= 1'b0;
			little_endian_q <= 1'b0;
			entry_count_q   <= '0;
			replacement_q   <= '0;
			limit_q         <= ccc_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ccc_pkg::REG_TO_UNICODE:    to_unicode_q    <= cfg_data[0];
				ccc_pkg::REG_LITTLE_ENDIAN: little_endian_q <= cfg_data[0];
				ccc_pkg::REG_ENTRY_COUNT:   entry_count_q   <= cfg_data;
				ccc_pkg::REG_REPLACEMENT:   replacement_q   <= cfg_data;
				ccc_pkg::REG_OUTPUT_LIMIT:  limit_q         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			ended_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= fin;
			if (fin) begin
				pos_q   <= pos_next;
				ended_q <= res_last;
			end else if (conv_req) begin
				pos_q   <= pos_eff;
				ended_q <= end_eff || lim_stop;
			end
			unique case (state_q)
				ST_IDLE: if (go_search) begin
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: if (pstat.match || pstat.final_step) begin
					state_q <= ST_IDLE;
				end else begin
					state_q <= ST_READ;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			chr_q <= chr_sw;
		end
		if (fin) begin
			code  <= res_code;
			found <= fin_ok;
			last  <= res_last;
		end
	end

endmodule

### hw/rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks of the code table converter, bound to the top level.
// ----------------------------------------------------------------------------
module ccc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       kind,
	input logic                       done,
	input logic [ccc_pkg::CODE_W-1:0] code,
	input logic                       found,
	input logic                       last
);

	// a result only shows once the sequencer is back to idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a load request finishes at once and gives no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == ccc_pkg::KIND_LOAD)) |=> (!done && !busy))
		else $error("load request produced a result or busy");

	// busy only rises on an accepted request
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// an unmatched zero code is always a terminator
	a_zero_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found && (code == '0)) |-> last)
		else $error("zero code without last");

endmodule

bind charset_code_table_converter ccc_checker u_ccc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done),
	.code   (code),
	.found  (found),
	.last   (last)
);
